// ===== rtl/sled_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and command codes for the SPI command LED strip controller.
// Depends on nothing; used by spi_command_led_strip_controller.
package sled_pkg;

	// Command codes: the low nibble of a received byte that has bit 7 set.
	localparam logic [3:0] CMD_LED_ON    = 4'd0;
	localparam logic [3:0] CMD_LED_OFF   = 4'd1;
	localparam logic [3:0] CMD_SET_DUTY  = 4'd2;
	localparam logic [3:0] CMD_CLEAR     = 4'd3;
	localparam logic [3:0] CMD_FILL      = 4'd4;
	localparam logic [3:0] CMD_READ_DUTY = 4'd13;
	localparam logic [3:0] CMD_READ_TEMP = 4'd14;
	localparam logic [3:0] CMD_READ_STAT = 4'd15;

	// Item source codes.
	localparam logic FUNC_SPI   = 1'b0;
	localparam logic FUNC_STRIP = 1'b1;

	// Color phases of one LED on the strip.
	localparam logic [1:0] PHASE_GREEN = 2'd0;
	localparam logic [1:0] PHASE_RED   = 2'd1;
	localparam logic [1:0] PHASE_BLUE  = 2'd2;

	localparam logic [6:0] DUTY_MAX   = 7'd100;
	localparam logic [2:0] COUNT_MAX  = 3'd7;

	typedef struct packed {
		logic       func;
		logic [7:0] spi_byte;
		logic [7:0] temperature;
	} item_t;

	typedef struct packed {
		logic [7:0] reply_byte;
		logic       led_enable;
		logic [6:0] duty_percent;
		logic       strip_send;
		logic [6:0] strip_byte;
		logic       strip_last;
	} result_t;

endpackage

// ===== rtl/spi_command_led_strip_controller.sv =====
`timescale 1ns / 1ps
// Top level of the SPI command decoder and LED strip controller.
// Depends on sled_pkg for the word types and the command codes.
//
// Usage: every input word is either a byte received from the SPI master
// (func = 0) or a handshake from the LED strip (func = 1). A received byte with
// bit 7 set is a command selected by its low nibble; other bytes are data for
// the last command. Every input word produces exactly one result word carrying
// the reply byte for the master's next transfer, the power LED enable and duty,
// and at most one color byte for the strip (green, red, blue for every LED).
// Clear and fill send the first strip byte at once; each strip handshake then
// sends the next one until the blue byte of the last LED, flagged strip_last.
//
// A word's result is registered on acceptance and shows in the cycle after.
// Throughput is one word per cycle while the receiver does not stall; the decode
// and the strip sequencer are a single pass of logic into the result register.
// When the receiver stalls, the result register holds its word and the input
// stays open only if that word is being taken in the same cycle.
// Reset clears all state, parks the strip sequencer idle (position equal to the
// LED count) and empties the result register.
module spi_command_led_strip_controller #(
	parameter int LED_TOTAL = 20
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             item_valid,
	output logic             item_ready,
	input  sled_pkg::item_t   item,
	output logic             result_valid,
	input  logic             result_ready,
	output sled_pkg::result_t result
);

	// Position counts up to LED_TOTAL itself, which marks the idle strip.
	localparam int POS_W = $clog2(LED_TOTAL + 1);
	localparam logic [POS_W-1:0] POS_IDLE = POS_W'(LED_TOTAL);
	localparam logic [POS_W-1:0] POS_LAST = POS_W'(LED_TOTAL - 1);

	// Architectural state.
	logic [3:0]       command_q;
	logic [2:0]       count_q;
	logic [6:0]       duty_q;
	logic             led_on_q;
	logic [6:0]       pend_red_q;
	logic [6:0]       pend_green_q;
	logic [6:0]       shown_red_q;
	logic [6:0]       shown_green_q;
	logic [6:0]       shown_blue_q;
	logic [POS_W-1:0] pos_q;
	logic [1:0]       phase_q;

	// Next-state and result values for the word being accepted.
	logic [3:0]       command_d;
	logic [2:0]       count_d;
	logic [6:0]       duty_d;
	logic             led_on_d;
	logic [6:0]       pend_red_d;
	logic [6:0]       pend_green_d;
	logic [6:0]       shown_red_d;
	logic [6:0]       shown_green_d;
	logic [6:0]       shown_blue_d;
	logic [POS_W-1:0] pos_d;
	logic [1:0]       phase_d;
	logic             start;
	logic             advance;
	logic [POS_W-1:0] seq_pos;
	logic [1:0]       seq_phase;
	logic [7:0]       reply;
	sled_pkg::result_t result_d;
	logic             accept;

	assign item_ready = !result_valid || result_ready;
	assign accept     = item_valid && item_ready;

	// Command decode and data handling.
	always_comb begin
		command_d     = command_q;
		count_d       = count_q;
		duty_d        = duty_q;
		led_on_d      = led_on_q;
		pend_red_d    = pend_red_q;
		pend_green_d  = pend_green_q;
		shown_red_d   = shown_red_q;
		shown_green_d = shown_green_q;
		shown_blue_d  = shown_blue_q;
		start         = 1'b0;
		reply         = 8'd0;
		if (item.func == sled_pkg::FUNC_SPI) begin
			if (item.spi_byte[7]) begin
				count_d   = 3'd0;
				command_d = item.spi_byte[3:0];
				unique case (item.spi_byte[3:0])
					sled_pkg::CMD_LED_ON:  led_on_d = 1'b1;
					sled_pkg::CMD_LED_OFF: led_on_d = 1'b0;
					sled_pkg::CMD_CLEAR: begin
						shown_red_d   = 7'd0;
						shown_green_d = 7'd0;
						shown_blue_d  = 7'd0;
						start         = 1'b1;
					end
					sled_pkg::CMD_READ_DUTY: reply = {1'b0, duty_q};
					sled_pkg::CMD_READ_TEMP: reply = item.temperature;
					sled_pkg::CMD_READ_STAT: reply = {7'd0, led_on_q};
					default: ;
				endcase
			end else begin
				// The data count saturates so that late fill bytes are ignored.
				if (count_q != sled_pkg::COUNT_MAX) begin
					count_d = count_q + 3'd1;
				end
				if (command_q == sled_pkg::CMD_SET_DUTY) begin
					duty_d = (item.spi_byte > {1'b0, sled_pkg::DUTY_MAX})
						? sled_pkg::DUTY_MAX : item.spi_byte[6:0];
				end else if (command_q == sled_pkg::CMD_FILL) begin
					unique case (count_d)
						3'd1: pend_red_d   = item.spi_byte[6:0];
						3'd2: pend_green_d = item.spi_byte[6:0];
						3'd3: begin
							shown_red_d   = pend_red_q;
							shown_green_d = pend_green_q;
							shown_blue_d  = item.spi_byte[6:0];
							start         = 1'b1;
						end
						default: ;
					endcase
				end
			end
		end
	end

	// Strip sequencer: a start restarts at the first LED, green byte, and
	// sends that byte in the same word; a handshake sends the next byte.
	always_comb begin
		seq_pos   = start ? '0 : pos_q;
		seq_phase = start ? sled_pkg::PHASE_GREEN : phase_q;
		advance   = (start || item.func == sled_pkg::FUNC_STRIP)
			&& (seq_pos < POS_IDLE) && (seq_phase <= sled_pkg::PHASE_BLUE);
		pos_d     = seq_pos;
		phase_d   = seq_phase;
		result_d  = '0;
		result_d.reply_byte   = reply;
		result_d.led_enable   = led_on_d;
		result_d.duty_percent = duty_d;
		if (advance) begin
			result_d.strip_send = 1'b1;
			unique case (seq_phase)
				sled_pkg::PHASE_GREEN: result_d.strip_byte = shown_green_d;
				sled_pkg::PHASE_RED:   result_d.strip_byte = shown_red_d;
				default:               result_d.strip_byte = shown_blue_d;
			endcase
			if (seq_phase == sled_pkg::PHASE_BLUE) begin
				phase_d             = sled_pkg::PHASE_GREEN;
				pos_d               = seq_pos + POS_W'(1);
				result_d.strip_last = (seq_pos == POS_LAST);
			end else begin
				phase_d = seq_phase + 2'd1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			command_q     <= 4'd0;
			count_q       <= 3'd0;
			duty_q        <= 7'd0;
			led_on_q      <= 1'b0;
			pend_red_q    <= 7'd0;
			pend_green_q  <= 7'd0;
			shown_red_q   <= 7'd0;
			shown_green_q <= 7'd0;
			shown_blue_q  <= 7'd0;
			pos_q         <= POS_IDLE;
			phase_q       <= sled_pkg::PHASE_GREEN;
			result_valid  <= 1'b0;
		end else begin
			if (accept) begin
				command_q     <= command_d;
				count_q       <= count_d;
				duty_q        <= duty_d;
				led_on_q      <= led_on_d;
				pend_red_q    <= pend_red_d;
				pend_green_q  <= pend_green_d;
				shown_red_q   <= shown_red_d;
				shown_green_q <= shown_green_d;
				shown_blue_q  <= shown_blue_d;
				pos_q         <= pos_d;
				phase_q       <= phase_d;
				result_valid  <= 1'b1;
			end else if (result_ready) begin
				result_valid <= 1'b0;
			end
		end
	end

	// Result payload needs no reset; it is qualified by result_valid.
	always_ff @(posedge clk) begin
		if (accept) begin
			result <= result_d;
		end
	end

	// Every accepted word yields a result in the next cycle.
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> result_valid)
		else $error("accepted word produced no result");

	// The last-LED flag only rides on a byte that is actually sent.
	a_last_with_send: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.strip_last |-> result.strip_send)
		else $error("strip_last without strip_send");

	// Duty stays within the clamp.
	a_duty_range: assert property (@(posedge clk) disable iff (!arst_n)
		duty_q <= sled_pkg::DUTY_MAX)
		else $error("duty above limit");

	// The sequencer never runs past the strip nor into an unused phase.
	a_seq_range: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q <= POS_IDLE && phase_q <= sled_pkg::PHASE_BLUE)
		else $error("strip sequencer out of range");

endmodule

// ===== sim/sled_result_checker.sv =====
`timescale 1ns / 1ps
// Result checker for the SPI command LED strip controller: predicts one result word per
// accepted input word and compares it field by field. Depends on sled_pkg.
module sled_result_checker #(
	parameter int LED_TOTAL = 20
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	input  logic              item_ready,
	input  sled_pkg::item_t   item,
	input  logic              result_valid,
	input  logic              result_ready,
	input  sled_pkg::result_t result,
	output int                errors,
	output int                outstanding,
	output int                results_seen,
	output int                strip_bytes,
	output int                frames_done
);

	// Predicted controller state.
	logic [3:0] cmd_now;
	logic [2:0] data_cnt;
	logic [6:0] duty;
	logic       led_state;
	logic [6:0] pend_red, pend_green;
	logic [6:0] show_red, show_green, show_blue;
	int         led_idx;
	logic [1:0] phase;

	sled_pkg::result_t due_results[$];
	int         err_cnt;

	// Puts the next strip byte into the word, if a strip frame is running.
	function automatic void emit_strip_byte(inout sled_pkg::result_t r);
		if (led_idx < LED_TOTAL && phase <= sled_pkg::PHASE_BLUE) begin
			r.strip_send = 1'b1;
			case (phase)
				sled_pkg::PHASE_GREEN: r.strip_byte = show_green;
				sled_pkg::PHASE_RED:   r.strip_byte = show_red;
				default:               r.strip_byte = show_blue;
			endcase
			if (phase == sled_pkg::PHASE_BLUE) begin
				phase = sled_pkg::PHASE_GREEN;
				led_idx++;
				if (led_idx == LED_TOTAL)
					r.strip_last = 1'b1;
			end else begin
				phase = phase + 2'd1;
			end
		end
	endfunction

	function automatic sled_pkg::result_t controller_response(sled_pkg::item_t w);
		sled_pkg::result_t r;
		r = '0;
		if (w.func == sled_pkg::FUNC_STRIP) begin
			emit_strip_byte(r);
		end else if (w.spi_byte[7]) begin
			data_cnt = '0;
			cmd_now = w.spi_byte[3:0];
			case (cmd_now)
				sled_pkg::CMD_LED_ON:    led_state = 1'b1;
				sled_pkg::CMD_LED_OFF:   led_state = 1'b0;
				sled_pkg::CMD_CLEAR: begin
					show_red = '0;
					show_green = '0;
					show_blue = '0;
					led_idx = 0;
					phase = sled_pkg::PHASE_GREEN;
					emit_strip_byte(r);
				end
				sled_pkg::CMD_READ_DUTY: r.reply_byte = {1'b0, duty};
				sled_pkg::CMD_READ_TEMP: r.reply_byte = w.temperature;
				sled_pkg::CMD_READ_STAT: r.reply_byte = {7'd0, led_state};
				default: ;
			endcase
		end else begin
			if (data_cnt < sled_pkg::COUNT_MAX)
				data_cnt = data_cnt + 3'd1;
			if (cmd_now == sled_pkg::CMD_SET_DUTY) begin
				duty = (w.spi_byte > sled_pkg::DUTY_MAX) ? sled_pkg::DUTY_MAX
					: w.spi_byte[6:0];
			end else if (cmd_now == sled_pkg::CMD_FILL) begin
				if (data_cnt == 3'd1) begin
					pend_red = w.spi_byte[6:0];
				end else if (data_cnt == 3'd2) begin
					pend_green = w.spi_byte[6:0];
				end else if (data_cnt == 3'd3) begin
					show_red = pend_red;
					show_green = pend_green;
					show_blue = w.spi_byte[6:0];
					led_idx = 0;
					phase = sled_pkg::PHASE_GREEN;
					emit_strip_byte(r);
				end
			end
		end
		r.led_enable = led_state;
		r.duty_percent = duty;
		return r;
	endfunction

	task automatic compare_field(input string field, input logic [7:0] want,
			input logic [7:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %h, got %h", $time, field, want, got);
			err_cnt++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		sled_pkg::result_t want;
		if (!arst_n) begin
			cmd_now = '0;
			data_cnt = '0;
			duty = '0;
			led_state = 1'b0;
			pend_red = '0;
			pend_green = '0;
			show_red = '0;
			show_green = '0;
			show_blue = '0;
			led_idx = LED_TOTAL;
			phase = sled_pkg::PHASE_GREEN;
			due_results.delete();
		end else begin
			// Results first: a word accepted at this edge cannot show its result yet.
			if (result_valid && result_ready) begin
				results_seen <= results_seen + 1;
				if (result.strip_send === 1'b1)
					strip_bytes <= strip_bytes + 1;
				if (result.strip_last === 1'b1)
					frames_done <= frames_done + 1;
				if (due_results.size() == 0) begin
					$display("%0t: result %h with nothing expected", $time, result);
					err_cnt++;
				end else begin
					want = due_results.pop_front();
					compare_field("reply_byte", want.reply_byte, result.reply_byte);
					compare_field("led_enable", 8'(want.led_enable), 8'(result.led_enable));
					compare_field("duty_percent", 8'(want.duty_percent),
						8'(result.duty_percent));
					compare_field("strip_send", 8'(want.strip_send), 8'(result.strip_send));
					compare_field("strip_byte", 8'(want.strip_byte), 8'(result.strip_byte));
					compare_field("strip_last", 8'(want.strip_last), 8'(result.strip_last));
				end
			end
			if (item_valid && item_ready)
				due_results.push_back(controller_response(item));
		end
		errors <= err_cnt;
		outstanding <= due_results.size();
	end

endmodule

// ===== sim/spi_command_led_strip_controller_tb.sv =====
`timescale 1ns / 1ps
// Testbench top for spi_command_led_strip_controller: drives input words and the result
// ready, and gives the verdict. Depends on sled_pkg, the block and sled_result_checker.
module spi_command_led_strip_controller_tb;

	localparam int LED_TOTAL = 20;
	// Cycles without any word accepted on either channel before the run is declared hung.
	localparam int HANG_LIMIT = 5000;
	// Words of random stimulus in each of the four pacing phases.
	localparam int PHASE_WORDS = 390;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              item_valid = 1'b0;
	logic              item_ready;
	sled_pkg::item_t   item = '0;
	logic              result_valid;
	logic              result_ready = 1'b0;
	sled_pkg::result_t result;

	int errors, outstanding, results_seen, strip_bytes, frames_done;
	int words_sent = 0;
	// Percent chance of a gap before each word, and of a stalled cycle on the result side.
	int idle_pct = 0;
	int stall_pct = 0;

	spi_command_led_strip_controller #(
		.LED_TOTAL(LED_TOTAL)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_ready(item_ready),
		.item(item),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.result(result)
	);

	sled_result_checker #(
		.LED_TOTAL(LED_TOTAL)
	) result_check (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_ready(item_ready),
		.item(item),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.result(result),
		.errors(errors),
		.outstanding(outstanding),
		.results_seen(results_seen),
		.strip_bytes(strip_bytes),
		.frames_done(frames_done)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	// The result side stalls at random, one decision per cycle, at the rate of the phase.
	always @(posedge clk) begin
		result_ready <= ($urandom_range(99) >= stall_pct);
	end

	// Offers one word and returns at the edge that accepts it. Valid is left high, so
	// back-to-back words keep it up without a drop; a gap lowers it before the next word.
	task automatic send_word(input logic fn, input logic [7:0] b, input logic [7:0] temp);
		sled_pkg::item_t w;
		w.func = fn;
		w.spi_byte = b;
		w.temperature = temp;
		while ($urandom_range(99) < idle_pct) begin
			item_valid <= 1'b0;
			@(posedge clk);
		end
		item_valid <= 1'b1;
		item <= w;
		@(posedge clk);
		while (!item_ready)
			@(posedge clk);
		words_sent++;
	endtask

	// A command byte carries its code in the low nibble; bits 6..4 are don't care.
	task automatic send_command(input logic [3:0] code);
		send_word(sled_pkg::FUNC_SPI, {1'b1, 3'($urandom_range(7)), code}, 8'($urandom));
	endtask

	task automatic send_data(input logic [6:0] value);
		send_word(sled_pkg::FUNC_SPI, {1'b0, value}, 8'($urandom));
	endtask

	// Handshakes carry random, ignored byte and temperature fields.
	task automatic send_handshakes(input int count);
		repeat (count)
			send_word(sled_pkg::FUNC_STRIP, 8'($urandom), 8'($urandom));
	endtask

	// Most strip runs end near the end of the frame (60 bytes for 20 LEDs), just short of
	// it or past it into handshakes while idle; the rest stop after at most 20 bytes.
	function automatic int strip_run_length();
		if ($urandom_range(2) == 0)
			return $urandom_range(0, 20);
		return $urandom_range(3 * LED_TOTAL - 3, 3 * LED_TOTAL + 4);
	endfunction

	task automatic run_random_sequence();
		int pick;
		pick = $urandom_range(99);
		if (pick < 28) begin
			// Complete fill: three color bytes, sometimes surplus data, then the strip run.
			send_command(sled_pkg::CMD_FILL);
			repeat (3)
				send_data(7'($urandom));
			if ($urandom_range(3) == 0)
				repeat ($urandom_range(1, 6))
					send_data(7'($urandom));
			send_handshakes(strip_run_length());
		end else if (pick < 38) begin
			send_command(sled_pkg::CMD_CLEAR);
			send_handshakes(strip_run_length());
		end else if (pick < 52) begin
			// Duty setting, biased toward the clamp boundary.
			send_command(sled_pkg::CMD_SET_DUTY);
			repeat ($urandom_range(1, 3))
				send_data($urandom_range(1) ? 7'($urandom_range(95, 127)) : 7'($urandom));
		end else if (pick < 66) begin
			case ($urandom_range(2))
				0: send_command(sled_pkg::CMD_READ_DUTY);
				1: send_command(sled_pkg::CMD_READ_TEMP);
				default: send_command(sled_pkg::CMD_READ_STAT);
			endcase
		end else if (pick < 76) begin
			send_command($urandom_range(1) ? sled_pkg::CMD_LED_ON : sled_pkg::CMD_LED_OFF);
		end else if (pick < 90) begin
			// Noise: any byte or a handshake, unknown command codes included.
			repeat ($urandom_range(1, 4))
				send_word(1'($urandom), 8'($urandom), 8'($urandom));
		end else begin
			// Broken fill: the color bytes stop short and another command takes over.
			send_command(sled_pkg::CMD_FILL);
			repeat ($urandom_range(0, 2))
				send_data(7'($urandom));
			send_command(4'($urandom));
			send_handshakes($urandom_range(0, 3));
		end
	endtask

	// Hang guard: ends the run if neither channel accepts a word for too long.
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < HANG_LIMIT) begin
			@(posedge clk);
			if ((item_valid && item_ready) || (result_valid && result_ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("spi_command_led_strip_controller_tb: errors");
		$finish;
	end

	initial begin : stimulus
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part, no idling on either side.
		send_handshakes(1);                       // handshake while the strip is idle
		send_word(sled_pkg::FUNC_SPI, 8'h8F, 8'h00);   // status with the LED off
		send_command(sled_pkg::CMD_LED_ON);
		send_word(sled_pkg::FUNC_SPI, 8'hFF, 8'hFF);   // status with the LED on
		send_command(sled_pkg::CMD_SET_DUTY);
		send_data(7'd0);
		send_data(7'd127);                        // clamped to the duty limit
		send_data(7'd101);                        // just above the limit
		send_data(7'd100);
		send_command(sled_pkg::CMD_READ_DUTY);
		send_word(sled_pkg::FUNC_SPI, 8'h8E, 8'hFF);   // temperature extremes
		send_word(sled_pkg::FUNC_SPI, 8'hBE, 8'h00);
		send_command(sled_pkg::CMD_FILL);
		send_data(7'h7F);
		send_data(7'h00);
		send_data(7'h55);                         // third color byte starts the strip
		send_data(7'h2A);                         // surplus fill data is ignored
		send_handshakes(2);
		send_word(sled_pkg::FUNC_SPI, 8'hC3, 8'h5A);   // clear restarts the running frame
		send_handshakes(1);
		send_command(4'd7);                       // unknown command code
		send_data(7'h12);                         // data with no use for it
		send_command(sled_pkg::CMD_LED_OFF);

		// Random part in four pacing phases: none, sender gaps, result stalls, both.
		for (int p = 0; p < 4; p++) begin
			case (p)
				0: begin idle_pct = 0;  stall_pct = 0;  end
				1: begin idle_pct = 51; stall_pct = 0;  end
				2: begin idle_pct = 0;  stall_pct = 51; end
				default: begin idle_pct = 32; stall_pct = 32; end
			endcase
			while (words_sent < 23 + (p + 1) * PHASE_WORDS)
				run_random_sequence();
		end

		item_valid <= 1'b0;
		// The count of words still due is registered, so it lags the last acceptance.
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
		// This wait lets any stray result show up.
		repeat (10) @(posedge clk);

		$display("Covered %0d input words over four pacing phases; %0d results checked,",
			words_sent, results_seen);
		$display("%0d strip bytes sent and %0d strip frames completed.",
			strip_bytes, frames_done);
		if (errors == 0 && outstanding == 0)
			$display("spi_command_led_strip_controller_tb: clean");
		else
			$display("spi_command_led_strip_controller_tb: errors");
		$finish;
	end

endmodule
